// File: rtl/core/candle_pattern_tolerance_match_top_defines.svh
// assertion macros for the candle pattern tolerance match block
// used by the port checker; no other dependencies
`ifndef CANDLE_PATTERN_TOLERANCE_MATCH_TOP_DEFINES_SVH
`define CANDLE_PATTERN_TOLERANCE_MATCH_TOP_DEFINES_SVH

// same-cycle implication
`define CPTM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CPTM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/cptm_pkg.sv
// shared widths, register indexes, payload structs and helpers
// for the candle pattern tolerance match block; no dependencies
`default_nettype none

package cptm_pkg;

   localparam int PRICE_BITS     = 20;
   localparam int VOL_BITS       = 24;
   localparam int CTOL_BITS      = 16;
   localparam int CTOL_FRAC      = 12;
   localparam int PROD_BITS      = PRICE_BITS + CTOL_BITS;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 24;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CANDLE_TOL = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VOLUME_TOL = CSR_INDEX_BITS'(1);

   typedef logic [PRICE_BITS-1:0] price_type;
   typedef logic [VOL_BITS-1:0]   vol_type;

   typedef struct packed {
      price_type a_open;
      price_type a_high;
      price_type a_low;
      price_type a_close;
      vol_type   a_volume;
      price_type b_open;
      price_type b_high;
      price_type b_low;
      price_type b_close;
      vol_type   b_volume;
      logic      context_match;
      logic      last;
   } req_type;

   typedef struct packed {
      price_type lo;
      price_type hi;
      price_type gap;
      logic      body_conflict;
      logic      volume_fail;
      logic      context_fail;
      logic      last;
   } feat_type;

   typedef struct packed {
      price_type span;
      price_type gap;
      logic      pass;
   } snap_type;

   function automatic price_type price_max(input price_type x, input price_type y);
      return (x > y) ? x : y;
   endfunction

   function automatic price_type price_min(input price_type x, input price_type y);
      return (x < y) ? x : y;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/cptm_item.sv
// request register and per-candle feature stage
// depends on cptm_pkg
`default_nettype none

module cptm_item (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  cptm_pkg::req_type                   in_req,
   input  logic [cptm_pkg::VOL_BITS-1:0]       volume_tol,
   output logic                                out_valid,
   input  logic                                out_ready,
   output cptm_pkg::feat_type                  out_feat
);

   logic               s0_valid_ff, s0_valid_in;
   logic               s1_valid_ff, s1_valid_in;
   cptm_pkg::req_type  req_ff, req_in;
   cptm_pkg::feat_type feat_ff, feat_in, feat_calc;
   logic               s0_ready, s1_ready;
   cptm_pkg::price_type d_open, d_close, d_high, d_low, d_oc, d_hl;
   cptm_pkg::vol_type   d_vol;

   function automatic cptm_pkg::price_type price_absdiff(input cptm_pkg::price_type x,
                                                         input cptm_pkg::price_type y);
      return (x >= y) ? (x - y) : (y - x);
   endfunction

   assign s1_ready = !s1_valid_ff || out_ready;
   assign s0_ready = !s0_valid_ff || s1_ready;
   assign in_ready = s0_ready;

   always_comb begin
      d_open  = price_absdiff(req_ff.a_open,  req_ff.b_open);
      d_close = price_absdiff(req_ff.a_close, req_ff.b_close);
      d_high  = price_absdiff(req_ff.a_high,  req_ff.b_high);
      d_low   = price_absdiff(req_ff.a_low,   req_ff.b_low);
      d_oc    = cptm_pkg::price_max(d_open, d_close);
      d_hl    = cptm_pkg::price_max(d_high, d_low);
      d_vol   = (req_ff.a_volume >= req_ff.b_volume) ? (req_ff.a_volume - req_ff.b_volume)
                                                     : (req_ff.b_volume - req_ff.a_volume);

      feat_calc.lo  = cptm_pkg::price_min(req_ff.a_low,  req_ff.b_low);
      feat_calc.hi  = cptm_pkg::price_max(req_ff.a_high, req_ff.b_high);
      feat_calc.gap = cptm_pkg::price_max(d_oc, d_hl);
      feat_calc.body_conflict =
         ((req_ff.a_open > req_ff.a_close) && (req_ff.b_open < req_ff.b_close)) ||
         ((req_ff.a_open < req_ff.a_close) && (req_ff.b_open > req_ff.b_close));
      feat_calc.volume_fail  = (volume_tol != '0) && (d_vol > volume_tol);
      feat_calc.context_fail = !req_ff.context_match;
      feat_calc.last         = req_ff.last;
   end

   always_comb begin
      s0_valid_in = s0_ready ? in_valid : s0_valid_ff;
      req_in      = (in_valid && s0_ready) ? in_req : req_ff;
      s1_valid_in = s1_ready ? s0_valid_ff : s1_valid_ff;
      feat_in     = (s0_valid_ff && s1_ready) ? feat_calc : feat_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      feat_ff <= feat_in;
   end

   assign out_valid = s1_valid_ff;
   assign out_feat  = feat_ff;

endmodule

`default_nettype wire

// File: rtl/core/cptm_acc.sv
// running range, worst gap and failure flags of one pattern pair
// depends on cptm_pkg
`default_nettype none

module cptm_acc (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  cptm_pkg::feat_type in_feat,
   output logic               out_valid,
   input  logic               out_ready,
   output cptm_pkg::snap_type out_snap
);

   cptm_pkg::price_type range_min_ff, range_min_in;
   cptm_pkg::price_type range_max_ff, range_max_in;
   cptm_pkg::price_type worst_gap_ff, worst_gap_in;
   logic                body_conflict_ff, body_conflict_in;
   logic                volume_fail_ff, volume_fail_in;
   logic                context_fail_ff, context_fail_in;
   logic                snap_valid_ff, snap_valid_in;
   cptm_pkg::snap_type  snap_ff, snap_in;
   cptm_pkg::price_type new_min, new_max, new_gap;
   logic                new_body, new_vol, new_ctx;
   logic                take;

   assign in_ready = !snap_valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      new_min  = cptm_pkg::price_min(range_min_ff, in_feat.lo);
      new_max  = cptm_pkg::price_max(range_max_ff, in_feat.hi);
      new_gap  = cptm_pkg::price_max(worst_gap_ff, in_feat.gap);
      new_body = body_conflict_ff || in_feat.body_conflict;
      new_vol  = volume_fail_ff   || in_feat.volume_fail;
      new_ctx  = context_fail_ff  || in_feat.context_fail;

      range_min_in     = range_min_ff;
      range_max_in     = range_max_ff;
      worst_gap_in     = worst_gap_ff;
      body_conflict_in = body_conflict_ff;
      volume_fail_in   = volume_fail_ff;
      context_fail_in  = context_fail_ff;
      snap_valid_in    = out_ready ? 1'b0 : snap_valid_ff;
      snap_in          = snap_ff;

      if (take && in_feat.last) begin
         // pair complete: hand over the summary and start afresh
         range_min_in     = '1;
         range_max_in     = '0;
         worst_gap_in     = '0;
         body_conflict_in = 1'b0;
         volume_fail_in   = 1'b0;
         context_fail_in  = 1'b0;
         snap_valid_in    = 1'b1;
         snap_in.span     = new_max - new_min;
         snap_in.gap      = new_gap;
         snap_in.pass     = !(new_body || new_vol || new_ctx) && !(new_max < new_min);
      end else if (take) begin
         range_min_in     = new_min;
         range_max_in     = new_max;
         worst_gap_in     = new_gap;
         body_conflict_in = new_body;
         volume_fail_in   = new_vol;
         context_fail_in  = new_ctx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_min_ff     <= '1;
         range_max_ff     <= '0;
         worst_gap_ff     <= '0;
         body_conflict_ff <= 1'b0;
         volume_fail_ff   <= 1'b0;
         context_fail_ff  <= 1'b0;
         snap_valid_ff    <= 1'b0;
      end else begin
         range_min_ff     <= range_min_in;
         range_max_ff     <= range_max_in;
         worst_gap_ff     <= worst_gap_in;
         body_conflict_ff <= body_conflict_in;
         volume_fail_ff   <= volume_fail_in;
         context_fail_ff  <= context_fail_in;
         snap_valid_ff    <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
   end

   assign out_valid = snap_valid_ff;
   assign out_snap  = snap_ff;

endmodule

`default_nettype wire

// File: rtl/core/cptm_judge.sv
// tolerance product stage and final compare into the response register
// depends on cptm_pkg
`default_nettype none

module cptm_judge (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  cptm_pkg::snap_type             in_snap,
   input  logic [cptm_pkg::CTOL_BITS-1:0] candle_tol,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic                           out_matched
);

   logic                            prod_valid_ff, prod_valid_in;
   logic [cptm_pkg::PROD_BITS-1:0]  prod_ff, prod_in;
   cptm_pkg::price_type             gap_ff, gap_in;
   logic                            pass_ff, pass_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            matched_ff, matched_in;
   logic [cptm_pkg::PROD_BITS-1:0]  scaled_gap;
   logic                            prod_ready, rsp_ready_int, load_prod, load_rsp;

   assign rsp_ready_int = !rsp_valid_ff || out_ready;
   assign prod_ready    = !prod_valid_ff || rsp_ready_int;
   assign in_ready      = prod_ready;
   assign load_prod     = in_valid && prod_ready;
   assign load_rsp      = prod_valid_ff && rsp_ready_int;

   assign scaled_gap = cptm_pkg::PROD_BITS'({gap_ff, {cptm_pkg::CTOL_FRAC{1'b0}}});

   always_comb begin
      prod_valid_in = prod_ready ? in_valid : prod_valid_ff;
      prod_in       = load_prod ? (cptm_pkg::PROD_BITS'(in_snap.span) *
                                   cptm_pkg::PROD_BITS'(candle_tol)) : prod_ff;
      gap_in        = load_prod ? in_snap.gap  : gap_ff;
      pass_in       = load_prod ? in_snap.pass : pass_ff;
      rsp_valid_in  = rsp_ready_int ? prod_valid_ff : rsp_valid_ff;
      matched_in    = load_rsp ? (pass_ff && !(scaled_gap > prod_ff)) : matched_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      gap_ff     <= gap_in;
      pass_ff    <= pass_in;
      matched_ff <= matched_in;
   end

   assign out_valid   = rsp_valid_ff;
   assign out_matched = matched_ff;

endmodule

`default_nettype wire

// File: rtl/core/candle_pattern_tolerance_match_top.sv
// Candle pattern tolerance match. One request per clock, while req_ready is high, carries
// one candle position of two normalized patterns; the block folds it into a running low,
// high, worst price gap and failure flags, and on a request marked last returns one response
// telling if the pair has no failure flag and fits within range times candle tolerance,
// then starts over for the next pair. A last request's response passes through the request
// register, feature stage, accumulator, product register and response register, each stage
// stalling only when the one after it is full, so requests enter while earlier ones are in
// flight. Write the tolerance registers only while no pair is in flight.
// depends on cptm_pkg, cptm_item, cptm_acc, cptm_judge
`default_nettype none

module candle_pattern_tolerance_match_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [cptm_pkg::PRICE_BITS-1:0]     req_a_open,
   input  logic [cptm_pkg::PRICE_BITS-1:0]     req_a_high,
   input  logic [cptm_pkg::PRICE_BITS-1:0]     req_a_low,
   input  logic [cptm_pkg::PRICE_BITS-1:0]     req_a_close,
   input  logic [cptm_pkg::VOL_BITS-1:0]       req_a_volume,
   input  logic [cptm_pkg::PRICE_BITS-1:0]     req_b_open,
   input  logic [cptm_pkg::PRICE_BITS-1:0]     req_b_high,
   input  logic [cptm_pkg::PRICE_BITS-1:0]     req_b_low,
   input  logic [cptm_pkg::PRICE_BITS-1:0]     req_b_close,
   input  logic [cptm_pkg::VOL_BITS-1:0]       req_b_volume,
   input  logic                                req_context_match,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_matched,
   input  logic                                csr_write_en,
   input  logic [cptm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [cptm_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   logic [cptm_pkg::CTOL_BITS-1:0] candle_tol_ff, candle_tol_in;
   logic [cptm_pkg::VOL_BITS-1:0]  volume_tol_ff, volume_tol_in;
   cptm_pkg::req_type              req_bus;
   cptm_pkg::feat_type             feat;
   cptm_pkg::snap_type             snap;
   logic                           feat_valid, feat_ready, snap_valid, snap_ready;

   always_comb begin
      candle_tol_in = candle_tol_ff;
      volume_tol_in = volume_tol_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            cptm_pkg::CSR_CANDLE_TOL: candle_tol_in = csr_wdata[cptm_pkg::CTOL_BITS-1:0];
            cptm_pkg::CSR_VOLUME_TOL: volume_tol_in = csr_wdata[cptm_pkg::VOL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         candle_tol_ff <= '0;
         volume_tol_ff <= '0;
      end else begin
         candle_tol_ff <= candle_tol_in;
         volume_tol_ff <= volume_tol_in;
      end
   end

   always_comb begin
      req_bus.a_open        = req_a_open;
      req_bus.a_high        = req_a_high;
      req_bus.a_low         = req_a_low;
      req_bus.a_close       = req_a_close;
      req_bus.a_volume      = req_a_volume;
      req_bus.b_open        = req_b_open;
      req_bus.b_high        = req_b_high;
      req_bus.b_low         = req_b_low;
      req_bus.b_close       = req_b_close;
      req_bus.b_volume      = req_b_volume;
      req_bus.context_match = req_context_match;
      req_bus.last          = req_last;
   end

   cptm_item u_item (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_req     (req_bus),
      .volume_tol (volume_tol_ff),
      .out_valid  (feat_valid),
      .out_ready  (feat_ready),
      .out_feat   (feat)
   );

   cptm_acc u_acc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (feat_valid),
      .in_ready  (feat_ready),
      .in_feat   (feat),
      .out_valid (snap_valid),
      .out_ready (snap_ready),
      .out_snap  (snap)
   );

   cptm_judge u_judge (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (snap_valid),
      .in_ready    (snap_ready),
      .in_snap     (snap),
      .candle_tol  (candle_tol_ff),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_matched (rsp_matched)
   );

endmodule

`default_nettype wire

// File: rtl/core/cptm_checker.sv
// port-level checks on the candle pattern tolerance match top level, bound to it below
// depends on candle_pattern_tolerance_match_top_defines.svh
`default_nettype none
`include "candle_pattern_tolerance_match_top_defines.svh"

module cptm_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_matched
);

   logic quiet;

   assign quiet = !(req_valid && req_ready) && rsp_ready;

   `CPTM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_matched), "response dropped or changed while stalled")

   `CPTM_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid, "response valid right after reset")

   `CPTM_ASSERT_SAME(a_stall_source, clock, reset, !req_ready, rsp_valid && !rsp_ready, "request stalled without a stalled response")

   `CPTM_ASSERT_SAME(a_drain, clock, reset, $past(quiet, 1) && $past(quiet, 2) && $past(quiet, 3) && $past(quiet, 4) && $past(quiet, 5), !rsp_valid, "response with no request left in flight")

endmodule

bind candle_pattern_tolerance_match_top cptm_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_matched (rsp_matched)
);

`default_nettype wire
